// ===== src/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int MAX_DIGITS_DEF = 32;

   localparam logic [5:0] RADIX_MIN     = 6'd2;
   localparam logic [5:0] RADIX_MAX     = 6'd36;
   localparam logic [5:0] DECIMAL_LIMIT = 6'd10;
   localparam logic [6:0] CHAR_ZERO     = 7'd48;
   localparam logic [6:0] CHAR_LOWER_A  = 7'd97;

   typedef struct packed {
      logic [31:0] value;
      logic [5:0]  radix;
   } req_type;

   typedef struct packed {
      logic [6:0] digit_char;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic [5:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   function automatic logic [5:0] clamp_radix(input logic [5:0] r);
      logic [5:0] res;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

   function automatic logic [6:0] digit_to_char(input logic [5:0] d);
      logic [6:0] res;
      if (d < DECIMAL_LIMIT) begin
         res = CHAR_ZERO + {1'b0, d};
      end else begin
         res = CHAR_LOWER_A + {1'b0, d} - {1'b0, DECIMAL_LIMIT};
      end
      return res;
   endfunction

endpackage

// ===== src/itoa_div.sv =====
// ----------------------------------------------------------------------------
// itoa_div
// Restoring divider by a small base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itoa_div #(
   parameter int W = itoa_pkg::VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  itoa_pkg::div_ctl_type  ctl,
   input  logic [W-1:0]           dividend,
   output itoa_pkg::div_sts_type  sts,
   output logic [W-1:0]           quotient,
   output logic [5:0]             remainder
);
   import itoa_pkg::*;

   localparam int CNW = $clog2(W);

   logic [W-1:0]   quo_ff, quo_in;
   logic [5:0]     rem_ff, rem_in;
   logic [5:0]     dvs_ff, dvs_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [6:0]     trial;
   logic           fits;

   assign trial = {rem_ff, quo_ff[W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = ctl.divisor;
         cnt_in  = CNW'(W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[W-2:0], fits};
         rem_in = fits ? 6'(trial - {1'b0, dvs_ff}) : trial[5:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctl.start) else $error("divider restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without a running division");
   a_rem_below_dvs: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < dvs_ff) else $error("remainder not below divisor");

endmodule

// ===== src/integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts an unsigned value to lower-case ASCII digits in base 2 to 36.
// ----------------------------------------------------------------------------
// One request at a time. With D = min(VALUE_BITS,32), a shared restoring
// divider produces each digit as D quotient bits, one per cycle, then stores
// the digit and restarts, storing digits least significant first; the store is
// then read back most significant first, each digit passing through a read
// state and an output state that waits for rsp_ready; req_ready is high only
// between requests. Radix is clamped into 2..36; only the low D value bits are
// used; at most MAX_DIGITS digits are kept.
module integer_to_ascii_radix #(
   parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itoa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   localparam int DW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int AW = $clog2(MAX_DIGITS);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_READ, ST_OUT} state_type;

   state_type   state_ff, state_in;
   logic [5:0]  base_ff, base_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        last_ff, last_in;

   logic [5:0]  digit_store_ff [MAX_DIGITS];
   logic [5:0]  rd_data_ff;
   logic        wr_en;
   logic        rd_en;
   logic [CW-1:0] count_inc;

   div_ctl_type div_ctl;
   div_sts_type div_sts;
   logic [DW-1:0] div_dividend;
   logic [DW-1:0] div_quotient;
   logic [5:0]    div_remainder;

   itoa_div #(.W(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .sts       (div_sts),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign count_inc = count_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      rsp_valid_in  = rsp_valid_ff;
      last_in       = last_ff;
      div_ctl.start   = 1'b0;
      div_ctl.divisor = base_ff;
      div_dividend    = div_quotient;
      wr_en = 1'b0;
      rd_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               base_in         = clamp_radix(req_data.radix);
               div_ctl.start   = 1'b1;
               div_ctl.divisor = clamp_radix(req_data.radix);
               div_dividend    = DW'(req_data.value);
               count_in        = '0;
               state_in        = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               wr_en    = 1'b1;
               count_in = count_inc;
               if (div_quotient != '0 && count_inc < CW'(MAX_DIGITS)) begin
                  div_ctl.start = 1'b1;
               end else begin
                  ptr_in   = AW'(count_ff);
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en        = 1'b1;
            rsp_valid_in = 1'b1;
            last_in      = (ptr_ff == '0);
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff - 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      ptr_ff  <= ptr_in;
      last_ff <= last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_store_ff[count_ff[AW-1:0]] <= div_remainder;
      end
      if (rd_en) begin
         rd_data_ff <= digit_store_ff[ptr_ff];
      end
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.digit_char = digit_to_char(rd_data_ff);
   assign rsp_data.last       = last_ff;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after request");
   a_rsp_not_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("response while idle");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last |=> req_ready)
      else $error("not idle after final digit");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_DIGITS)) else $error("digit count overflow");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_ascii_radix.
// Requests of value and radix go in through a queue-fed driver with random
// gaps. Each accepted request is expanded here into its expected ASCII digits,
// most significant first. The monitor compares every digit that comes out,
// under random back-pressure, against the oldest expected digit.
// ----------------------------------------------------------------------------
module tb;
   import itoa_pkg::*;

   localparam int          MAX_DIGITS = 32;
   localparam int          RAND_ITEMS = 320;
   localparam int unsigned LIMIT      = 4_000_000;

   typedef struct {
      req_type req;
      bit      drain;
   } stim_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   stim_type    stim_q[$];
   stim_type    next_item;
   rsp_type     digit_q[$];
   rsp_type     want;
   logic        req_fire  = 1'b0;
   int unsigned req_gap   = 0;
   int unsigned req_calm  = 0;
   int unsigned rsp_stall = 0;
   int unsigned rsp_calm  = 0;
   int unsigned req_count = 0;
   int unsigned stim_total;
   int unsigned cycle_count;
   int          fail_count = 0;

   integer_to_ascii_radix DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned idle_len(inout int unsigned calm,
                                            input int unsigned zero_pct);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if (roll < 2) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (roll < zero_pct) return 0;
      if (roll < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [5:0] eff_base(input logic [5:0] r);
      if (r < RADIX_MIN) return RADIX_MIN;
      if (r > RADIX_MAX) return RADIX_MAX;
      return r;
   endfunction

   // repeated division, remainders collected least significant first
   task automatic push_digits(input req_type r);
      logic [31:0] rem;
      logic [31:0] base;
      logic [31:0] d;
      logic [5:0]  digs[$];
      rsp_type     item;
      rem  = r.value;
      base = {26'd0, eff_base(r.radix)};
      do begin
         d = rem % base;
         digs.push_front(d[5:0]);
         rem = rem / base;
      end while (rem != 0 && digs.size() < MAX_DIGITS);
      foreach (digs[k]) begin
         if (digs[k] < DECIMAL_LIMIT) item.digit_char = CHAR_ZERO + {1'b0, digs[k]};
         else item.digit_char = CHAR_LOWER_A + {1'b0, digs[k]} - {1'b0, DECIMAL_LIMIT};
         item.last = (k == digs.size() - 1);
         digit_q.push_back(item);
      end
   endtask

   task automatic add_req(input logic [31:0] v, input logic [5:0] r, input bit drain);
      stim_type s;
      s.req.value = v;
      s.req.radix = r;
      s.drain     = drain;
      stim_q.push_back(s);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (stim_q.size() == 0 || (stim_q[0].drain && digit_q.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            next_item = stim_q.pop_front();
            req_data  <= next_item.req;
            req_valid <= 1'b1;
            req_gap   <= idle_len(req_calm, 50);
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall <= idle_len(rsp_calm, 75);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            push_digits(req_data);
            req_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (digit_q.size() == 0) begin
               $error("unexpected digit: digit_char %0d last %0b",
                      rsp_data.digit_char, rsp_data.last);
               fail_count++;
            end else begin
               want = digit_q.pop_front();
               if (rsp_data.digit_char !== want.digit_char) begin
                  $error("digit_char: expected %0d, got %0d",
                         want.digit_char, rsp_data.digit_char);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [31:0] val;
      logic [5:0]  rad;
      logic [63:0] pw;
      int unsigned k;

      // directed: zero, extremes, clamping, digit boundaries
      add_req(32'd0, 6'd10, 1'b0);
      add_req(32'd0, 6'd2, 1'b0);
      add_req(32'd0, 6'd36, 1'b0);
      add_req(32'hFFFF_FFFF, 6'd2, 1'b0);
      add_req(32'hFFFF_FFFF, 6'd36, 1'b0);
      add_req(32'hFFFF_FFFF, 6'd16, 1'b0);
      add_req(32'hFFFF_FFFF, 6'd10, 1'b0);
      add_req(32'd12345, 6'd0, 1'b0);
      add_req(32'd255, 6'd1, 1'b0);
      add_req(32'd1295, 6'd37, 1'b0);
      add_req(32'hFFFF_FFFF, 6'd63, 1'b0);
      add_req(32'd1, 6'd2, 1'b0);
      add_req(32'd35, 6'd36, 1'b0);
      add_req(32'd36, 6'd36, 1'b0);
      add_req(32'd9, 6'd10, 1'b0);
      add_req(32'd10, 6'd16, 1'b0);
      add_req(32'h8000_0000, 6'd2, 1'b0);
      add_req(32'hDEAD_BEEF, 6'd16, 1'b0);
      add_req(32'd1234567890, 6'd10, 1'b0);
      add_req(32'hAAAA_AAAA, 6'd3, 1'b0);
      add_req(32'h5555_5555, 6'd7, 1'b0);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 70) rad = 6'($urandom_range(2, 36));
         else rad = 6'($urandom_range(0, 63));
         case ($urandom_range(0, 5))
            0: val = $urandom_range(0, 255);
            1: val = $urandom() >> $urandom_range(0, 31);
            2: val = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
            3: begin
               pw = 64'd1;
               k  = $urandom_range(1, 32);
               repeat (k) begin
                  if (pw * eff_base(rad) <= 64'hFFFF_FFFF) pw = pw * eff_base(rad);
               end
               val = pw[31:0] - $urandom_range(0, 1);
            end
            default: val = $urandom();
         endcase
         add_req(val, rad, i == 0 || $urandom_range(0, 99) < 2);
      end
      stim_total = stim_q.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_count < stim_total) @(posedge clock);
      while (digit_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (digit_q.size() != 0) begin
         $error("%0d expected digits never arrived", digit_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
